// File: rtl/core/command_line_tokenizer_unit_defines.svh
// ----------------------------------------------------------------------------
// Command line tokenizer assertion macros
// Concurrent checks sampled on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef COMMAND_LINE_TOKENIZER_UNIT_DEFINES_SVH
`define COMMAND_LINE_TOKENIZER_UNIT_DEFINES_SVH

// Hold a condition at every edge.
`define CLTOK_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("cltok check failed");

// Require a consequent in the same cycle.
`define CLTOK_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cltok check failed");

// Require a consequent in the next cycle.
`define CLTOK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cltok check failed");

`endif

// File: rtl/core/cltok_pkg.sv
// ----------------------------------------------------------------------------
// Command line tokenizer package
// Sizes, character and result codes, and the beat and state types.
// ----------------------------------------------------------------------------
`default_nettype none

package cltok_pkg;

    localparam int MAX_ARGUMENTS = 32;
    localparam int TOKEN_BUFFER  = 128;

    localparam int ARG_W     = $clog2(MAX_ARGUMENTS);
    localparam int TOK_W     = $clog2(TOKEN_BUFFER);
    localparam int RES_SLOTS = 6;
    localparam int SLOT_W    = $clog2(RES_SLOTS);

    localparam logic [ARG_W-1:0] ARG_LIMIT = ARG_W'(MAX_ARGUMENTS - 1);
    localparam logic [TOK_W-1:0] TOK_LIMIT = TOK_W'(TOKEN_BUFFER - 1);

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_LINE = 2'd2;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       line_last;
    } cmd_beat_t;

    typedef struct packed {
        logic [1:0] item_kind;
        logic [7:0] arg_byte;
        logic [4:0] arg_number;
        logic       truncated;
        logic       run_last;
    } tok_beat_t;

    typedef struct packed {
        logic       valid;
        tok_beat_t  beat;
    } res_slot_t;

    typedef struct packed {
        logic [7:0]       held_byte;
        logic             held_valid;
        logic [7:0]       previous_byte;
        logic             in_single_quote;
        logic             in_double_quote;
        logic             escape_pending;
        logic             pending_split;
        logic             split_next;
        logic [TOK_W-1:0] token_length;
        logic [ARG_W-1:0] arg_count;
        logic             stopped;
        logic             token_dropped;
    } tok_state_t;

endpackage

`default_nettype wire

// File: rtl/core/command_line_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// Command line tokenizer
// Takes one command-line byte per beat on cmd, the final byte of a line
// flagged, and returns argument bytes, argument-end and line-end beats on tok.
// Each byte is settled when the byte after it arrives, so a beat's results
// cover the byte held from the previous beat and, on the final byte, the
// rest of the line. All results of a beat are worked out in the cycle the
// beat is taken and land in a six-entry result register that drains one
// beat per cycle while tok_ready is high. A new cmd beat is taken once at
// most one result is left and that one is leaving, so every result beyond
// the first that a byte causes holds off the next byte; the rate is set by
// the single tok beat per cycle out of the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "command_line_tokenizer_unit_defines.svh"

module command_line_tokenizer_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  cltok_pkg::cmd_beat_t  cmd_data,
    output logic                  tok_valid,
    input  logic                  tok_ready,
    output cltok_pkg::tok_beat_t  tok_data
);
    import cltok_pkg::*;

    tok_state_t             state_reg;
    tok_state_t             state_next;
    res_slot_t              slot_next [RES_SLOTS];
    tok_beat_t              slot_reg  [RES_SLOTS];
    logic [RES_SLOTS-1:0]   mask_reg;
    logic [RES_SLOTS-1:0]   mask_next;
    logic [RES_SLOTS-1:0]   new_mask;

    tok_state_t             s_a;
    tok_state_t             s_1;
    tok_state_t             s_b;
    res_slot_t              a_close;
    res_slot_t              a_add;
    res_slot_t              b_close;
    res_slot_t              b_add;
    logic                   a_consumed;
    logic                   b_consumed;
    logic                   en_a;
    logic                   en_b;
    logic                   last;
    logic                   fin_close;
    logic [ARG_W-1:0]       count_end;

    logic                   accept;
    logic                   tok_done;
    logic                   single;
    logic [SLOT_W-1:0]      sel_idx;

    assign accept = cmd_valid && cmd_ready;
    assign last   = cmd_data.line_last;
    assign en_a   = state_reg.held_valid && !state_reg.escape_pending;

    cltok_decide u_decide_held (
        .enable    (en_a),
        .state_in  (state_reg),
        .cur_char  (state_reg.held_byte),
        .has_next  (1'b1),
        .next_char (cmd_data.line_byte),
        .state_out (s_a),
        .close_res (a_close),
        .add_res   (a_add),
        .consumed  (a_consumed)
    );

    always_comb
    begin
        s_1 = s_a;
        if (!state_reg.stopped && state_reg.held_valid && state_reg.escape_pending)
        begin
            s_1.escape_pending = 1'b0;
        end
        if (a_consumed)
        begin
            s_1.escape_pending = 1'b1;
        end
    end

    assign en_b = last && !s_1.escape_pending;

    cltok_decide u_decide_last (
        .enable    (en_b),
        .state_in  (s_1),
        .cur_char  (cmd_data.line_byte),
        .has_next  (1'b0),
        .next_char (8'h00),
        .state_out (s_b),
        .close_res (b_close),
        .add_res   (b_add),
        .consumed  (b_consumed)
    );

    assign fin_close = last && !s_b.stopped && (s_b.token_length != '0 || s_b.token_dropped);
    assign count_end = s_b.arg_count + ARG_W'(fin_close);

    always_comb
    begin
        slot_next[0] = a_close;
        slot_next[1] = a_add;
        slot_next[2] = b_close;
        slot_next[3] = b_add;

        slot_next[4]                 = '0;
        slot_next[4].valid           = fin_close;
        slot_next[4].beat.item_kind  = KIND_END;
        slot_next[4].beat.arg_number = 5'(s_b.arg_count);
        slot_next[4].beat.truncated  = s_b.token_dropped;

        slot_next[5]                 = '0;
        slot_next[5].valid           = last;
        slot_next[5].beat.item_kind  = KIND_LINE;
        slot_next[5].beat.arg_number = 5'(count_end);
        slot_next[5].beat.truncated  = s_b.stopped;

        for (int i = 0; i < RES_SLOTS; i++)
        begin
            new_mask[i] = slot_next[i].valid;
        end

        if (last)
        begin
            state_next = '0;
        end
        else
        begin
            state_next            = s_1;
            state_next.held_byte  = cmd_data.line_byte;
            state_next.held_valid = 1'b1;
        end
    end

    // Output side: lowest pending slot goes first.
    always_comb
    begin
        sel_idx = '0;
        for (int i = RES_SLOTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel_idx = SLOT_W'(i);
            end
        end
        single            = (mask_reg & (mask_reg - RES_SLOTS'(1))) == '0;
        tok_valid         = mask_reg != '0;
        tok_data          = slot_reg[sel_idx];
        tok_data.run_last = single;
        tok_done          = tok_valid && tok_ready;
        cmd_ready         = !tok_valid || (single && tok_ready);

        if (accept)
        begin
            mask_next = new_mask;
        end
        else if (tok_done)
        begin
            mask_next = mask_reg & ~(RES_SLOTS'(1) << sel_idx);
        end
        else
        begin
            mask_next = mask_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            mask_reg  <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (accept)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < RES_SLOTS; i++)
            begin
                slot_reg[i] <= slot_next[i].beat;
            end
        end
    end

    `CLTOK_ASSERT_ALWAYS(a_arg_bound, state_reg.arg_count <= ARG_LIMIT)
    `CLTOK_ASSERT_ALWAYS(a_tok_bound, state_reg.token_length <= TOK_LIMIT)
    `CLTOK_ASSERT_ALWAYS(a_end_no_lookahead, !b_consumed)
    `CLTOK_ASSERT_IMPLIES(a_line_end_last, tok_valid && tok_data.item_kind == KIND_LINE, tok_data.run_last)
    `CLTOK_ASSERT_NEXT(a_line_clear, accept && cmd_data.line_last, !state_reg.held_valid && state_reg.arg_count == '0)

endmodule

`default_nettype wire

// File: rtl/core/cltok_decide.sv
// ----------------------------------------------------------------------------
// Command line tokenizer character decision
// Settles one character against its lookahead: quoting, escapes, splits,
// argument close and byte append, with the state that follows.
// ----------------------------------------------------------------------------
`default_nettype none

module cltok_decide (
    input  logic                   enable,
    input  cltok_pkg::tok_state_t  state_in,
    input  logic [7:0]             cur_char,
    input  logic                   has_next,
    input  logic [7:0]             next_char,
    output cltok_pkg::tok_state_t  state_out,
    output cltok_pkg::res_slot_t   close_res,
    output cltok_pkg::res_slot_t   add_res,
    output logic                   consumed
);
    import cltok_pkg::*;

    tok_state_t st;
    logic       split;
    logic       do_add;
    logic [7:0] add_char;

    always_comb
    begin
        st        = state_in;
        close_res = '0;
        add_res   = '0;
        consumed  = 1'b0;
        split     = 1'b0;
        do_add    = 1'b0;
        add_char  = cur_char;
        if (enable && !state_in.stopped)
        begin
            if (st.split_next)
            begin
                st.pending_split = 1'b1;
            end
            st.split_next = 1'b0;
            priority if (cur_char == CH_BSLASH)
            begin
                if (has_next)
                begin
                    do_add           = 1'b1;
                    add_char         = next_char;
                    consumed         = 1'b1;
                    st.previous_byte = next_char;
                end
                else
                begin
                    st.previous_byte = cur_char;
                end
            end
            else if (cur_char == CH_SQUOTE && !st.in_double_quote)
            begin
                st.in_single_quote = !st.in_single_quote;
                st.previous_byte   = cur_char;
            end
            else if (cur_char == CH_DQUOTE && !st.in_single_quote)
            begin
                st.in_double_quote = !st.in_double_quote;
                st.previous_byte   = cur_char;
            end
            else
            begin
                if (!st.in_single_quote && !st.in_double_quote)
                begin
                    if (cur_char == CH_SPACE)
                    begin
                        st.pending_split = 1'b1;
                    end
                    else if (cur_char == CH_SEMI)
                    begin
                        st.pending_split = 1'b1;
                        st.split_next    = 1'b1;
                    end
                    else if (cur_char == CH_AMP || cur_char == CH_PIPE)
                    begin
                        if (st.previous_byte == cur_char)
                        begin
                            st.split_next = 1'b1;
                        end
                        else if (has_next && next_char == cur_char)
                        begin
                            st.pending_split = 1'b1;
                        end
                    end
                end
                split            = st.pending_split;
                st.pending_split = 1'b0;
                if (split && (st.token_length != '0 || st.token_dropped))
                begin
                    close_res.valid           = 1'b1;
                    close_res.beat.item_kind  = KIND_END;
                    close_res.beat.arg_number = 5'(st.arg_count);
                    close_res.beat.truncated  = st.token_dropped;
                    st.arg_count              = st.arg_count + ARG_W'(1);
                    st.token_length           = '0;
                    st.token_dropped          = 1'b0;
                    if (st.arg_count >= ARG_LIMIT)
                    begin
                        st.stopped = 1'b1;
                    end
                end
                if (!st.stopped)
                begin
                    st.previous_byte = cur_char;
                end
                do_add = !st.stopped && !(split && cur_char == CH_SPACE);
            end
            if (do_add)
            begin
                if (st.token_length < TOK_LIMIT)
                begin
                    add_res.valid           = 1'b1;
                    add_res.beat.item_kind  = KIND_BYTE;
                    add_res.beat.arg_byte   = add_char;
                    add_res.beat.arg_number = 5'(st.arg_count);
                    st.token_length         = st.token_length + TOK_W'(1);
                end
                else
                begin
                    st.token_dropped = 1'b1;
                end
            end
        end
        state_out = st;
    end

endmodule

`default_nettype wire

// File: bench/command_line_tokenizer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Command line tokenizer testbench
// Streams command lines into cmd and checks every tok beat against a
// predictor that settles each byte against its lookahead. Short directed
// lines cover byte extremes, operators, escapes and quoting. A long
// argument, a line that overruns the argument limit and random lines with
// noise follow. Sender gaps and receiver stalls change over four phases.
// ----------------------------------------------------------------------------

module command_line_tokenizer_unit_tb;

    import cltok_pkg::*;

    localparam int STALL_LIMIT = 500;
    localparam int TARGET_BYTES = 270;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_ready;
    cmd_beat_t cmd_data = '0;
    logic      tok_valid;
    logic      tok_ready = 1'b0;
    tok_beat_t tok_data;

    cmd_beat_t pending_cmds[$];
    tok_beat_t expected_tokens[$];
    tok_beat_t beat_results[$];

    int errors = 0;
    int cmds_taken = 0;
    int total_cmds = 1;
    int tokens_checked = 0;
    int lines_parsed = 0;
    int clipped_args = 0;
    int capped_lines = 0;
    int quiet_cycles = 0;

    logic [7:0] held_chr;
    bit         held_ok;
    logic [7:0] last_settled;
    bit         in_sq;
    bit         in_dq;
    bit         escape_used;
    bit         split_due;
    bit         split_after;
    int         arg_len;
    int         args_done;
    bit         halted;
    bit         arg_lost;

    command_line_tokenizer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_data  (tok_data)
    );

    always #5 clk = ~clk;

    function automatic void clear_line();
        held_chr     = '0;
        held_ok      = 1'b0;
        last_settled = '0;
        in_sq        = 1'b0;
        in_dq        = 1'b0;
        escape_used  = 1'b0;
        split_due    = 1'b0;
        split_after  = 1'b0;
        arg_len      = 0;
        args_done    = 0;
        halted       = 1'b0;
        arg_lost     = 1'b0;
    endfunction

    function automatic void push_result(logic [1:0] kind, logic [7:0] chr, int num, bit trunc);
        tok_beat_t r;
        r.item_kind  = kind;
        r.arg_byte   = chr;
        r.arg_number = 5'(num);
        r.truncated  = trunc;
        r.run_last   = 1'b0;
        beat_results.push_back(r);
    endfunction

    function automatic void append_char(logic [7:0] c);
        if (arg_len < TOKEN_BUFFER - 1) begin
            push_result(KIND_BYTE, c, args_done, 1'b0);
            arg_len++;
        end
        else
            arg_lost = 1'b1;
    endfunction

    function automatic void close_arg();
        push_result(KIND_END, 8'h00, args_done, arg_lost);
        if (arg_lost)
            clipped_args++;
        args_done++;
        arg_len  = 0;
        arg_lost = 1'b0;
    endfunction

    // Settle one byte; return 1 when the lookahead was taken by an escape.
    function automatic bit settle_char(logic [7:0] c, bit has_next, logic [7:0] nxt);
        if (halted)
            return 1'b0;
        if (split_after)
            split_due = 1'b1;
        split_after = 1'b0;
        if (c == CH_BSLASH) begin
            if (has_next) begin
                append_char(nxt);
                last_settled = nxt;
                return 1'b1;
            end
            last_settled = c;
            return 1'b0;
        end
        if (c == CH_SQUOTE && !in_dq) begin
            in_sq = !in_sq;
            last_settled = c;
            return 1'b0;
        end
        if (c == CH_DQUOTE && !in_sq) begin
            in_dq = !in_dq;
            last_settled = c;
            return 1'b0;
        end
        if (!in_sq && !in_dq) begin
            if (c == CH_SPACE)
                split_due = 1'b1;
            else if (c == CH_SEMI) begin
                split_due   = 1'b1;
                split_after = 1'b1;
            end
            else if (c == CH_AMP || c == CH_PIPE) begin
                if (last_settled == c)
                    split_after = 1'b1;
                else if (has_next && nxt == c)
                    split_due = 1'b1;
            end
        end
        if (split_due) begin
            split_due = 1'b0;
            if (arg_len > 0 || arg_lost) begin
                close_arg();
                if (args_done >= MAX_ARGUMENTS - 1) begin
                    halted = 1'b1;
                    return 1'b0;
                end
            end
            if (c == CH_SPACE) begin
                last_settled = c;
                return 1'b0;
            end
        end
        append_char(c);
        last_settled = c;
        return 1'b0;
    endfunction

    function automatic void predict_tokens(cmd_beat_t b);
        beat_results.delete();
        if (!halted && held_ok) begin
            if (escape_used)
                escape_used = 1'b0;
            else if (settle_char(held_chr, 1'b1, b.line_byte))
                escape_used = 1'b1;
        end
        if (!b.line_last) begin
            held_chr = b.line_byte;
            held_ok  = 1'b1;
        end
        else begin
            if (!halted) begin
                if (escape_used)
                    escape_used = 1'b0;
                else
                    void'(settle_char(b.line_byte, 1'b0, 8'h00));
            end
            if (!halted && (arg_len > 0 || arg_lost))
                close_arg();
            push_result(KIND_LINE, 8'h00, args_done, halted);
            if (halted)
                capped_lines++;
            lines_parsed++;
            clear_line();
        end
        if (beat_results.size() != 0)
            beat_results[beat_results.size() - 1].run_last = 1'b1;
        foreach (beat_results[i])
            expected_tokens.push_back(beat_results[i]);
    endfunction

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= 40)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("tok beat %0d %s got %0h want %0h",
                                      tokens_checked, name, got, want));
    endtask

    task automatic check_token(tok_beat_t got);
        tok_beat_t want;
        if (expected_tokens.size() == 0) begin
            report_mismatch($sformatf("unexpected tok beat %h", got));
            return;
        end
        want = expected_tokens.pop_front();
        check_field("item_kind", got.item_kind, want.item_kind);
        check_field("arg_byte", got.arg_byte, want.arg_byte);
        check_field("arg_number", got.arg_number, want.arg_number);
        check_field("truncated", got.truncated, want.truncated);
        check_field("run_last", got.run_last, want.run_last);
        tokens_checked++;
    endtask

    function automatic int phase_now();
        int p;
        p = (cmds_taken * 4) / total_cmds;
        return (p > 3) ? 3 : p;
    endfunction

    function automatic bit sender_rests();
        case (phase_now())
            1:       return $urandom_range(99) < 62;
            3:       return $urandom_range(99) < 28;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (phase_now())
            2:       return $urandom_range(99) < 62;
            3:       return $urandom_range(99) < 28;
            default: return 1'b0;
        endcase
    endfunction

    task automatic queue_beat(logic [7:0] chr, bit last);
        cmd_beat_t b;
        b.line_byte = chr;
        b.line_last = last;
        pending_cmds.push_back(b);
    endtask

    task automatic queue_text(string s);
        for (int i = 0; i < s.len(); i++)
            queue_beat(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] letter();
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6: return letter();
            7, 8:                return CH_SPACE;
            9:                   return CH_SEMI;
            10, 11:              return CH_AMP;
            12, 13:              return CH_PIPE;
            14:                  return CH_BSLASH;
            15:                  return CH_SQUOTE;
            16:                  return CH_DQUOTE;
            default:             return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_special();
        case ($urandom_range(0, 6))
            0:       return CH_SPACE;
            1:       return CH_SEMI;
            2:       return CH_AMP;
            3:       return CH_PIPE;
            4:       return CH_BSLASH;
            5:       return CH_SQUOTE;
            default: return CH_DQUOTE;
        endcase
    endfunction

    task automatic queue_random_line();
        int len;
        int shape;
        logic [7:0] chr;
        shape = $urandom_range(0, 9);
        len   = (shape == 8) ? $urandom_range(1, 8) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
            case (shape)
                8:       chr = 8'($urandom_range(0, 255));
                9:       chr = pick_special();
                default: chr = pick_char();
            endcase
            queue_beat(chr, i == len - 1);
        end
    endtask

    task automatic queue_long_arg();
        int len;
        len = $urandom_range(126, 134);
        for (int i = 0; i < len; i++)
            queue_beat(letter(), 1'b0);
        queue_beat(CH_SPACE, 1'b0);
        queue_beat(letter(), 1'b1);
    endtask

    task automatic queue_many_args();
        int len;
        len = $urandom_range(34, 44);
        for (int i = 0; i < len; i++)
            queue_beat((i % 2) ? CH_SEMI : letter(), i == len - 1);
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            cmd_valid <= 1'b0;
            cmd_data  <= '0;
        end
        else begin
            if (cmd_valid && cmd_ready) begin
                predict_tokens(cmd_data);
                cmds_taken++;
            end
            if (!cmd_valid || cmd_ready) begin
                if (pending_cmds.size() != 0 && !sender_rests()) begin
                    cmd_valid <= 1'b1;
                    cmd_data  <= pending_cmds.pop_front();
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n)
            tok_ready <= 1'b0;
        else begin
            if (tok_valid && tok_ready)
                check_token(tok_data);
            tok_ready <= !receiver_stalls();
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((cmd_valid && cmd_ready) || (tok_valid && tok_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        bit long_done;
        bit many_done;
        long_done = 1'b0;
        many_done = 1'b0;
        clear_line();

        queue_beat(8'h00, 1'b1);
        queue_beat(8'hFF, 1'b1);
        queue_text("a&&b");
        queue_text("c||;");
        queue_text(" \\");
        queue_text("'x y");
        queue_text("\\;;");
        queue_text("  ");
        queue_text("\"'\"");

        while (pending_cmds.size() < TARGET_BYTES) begin
            if (!long_done && pending_cmds.size() >= 80) begin
                queue_long_arg();
                long_done = 1'b1;
            end
            else if (!many_done && pending_cmds.size() >= 230) begin
                queue_many_args();
                many_done = 1'b1;
            end
            else
                queue_random_line();
        end
        total_cmds = pending_cmds.size();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_cmds.size() != 0 || cmd_valid || expected_tokens.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("Run covered %0d command bytes in %0d lines; %0d tok beats checked.",
                 cmds_taken, lines_parsed, tokens_checked);
        $display("Clipped arguments: %0d, lines stopped at the argument limit: %0d.",
                 clipped_args, capped_lines);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
